// ===== design/fdre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdre_pkg
// Shared types, token codes and defaults of the frame delta run encoder.
// ----------------------------------------------------------------------------
package fdre_pkg;

    localparam int W_LIMIT_DEF = 2048;
    localparam int H_LIMIT_DEF = 2048;

    localparam int CFG_W        = 12;
    localparam int PIX_W        = 32;
    localparam int EXTRA_W      = 12;
    localparam int BURST_DEPTH  = 4;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_NEW    = 3'd0,
        KIND_RESIZE = 3'd1,
        KIND_SAME   = 3'd2,
        KIND_LEAD   = 3'd3,
        KIND_TRAIL  = 3'd4,
        KIND_LIT    = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [PIX_W-1:0]   value;
        logic [EXTRA_W-1:0] extra;
    } t_token;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
        logic             resize;
        logic             full;
        logic             last;
    } t_stage;

    function automatic t_token mk_tok(input t_kind kind, input logic [PIX_W-1:0] value,
                                      input logic [EXTRA_W-1:0] extra);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.extra = extra;
        return t;
    endfunction

    // Zero counts as one, values above the bound saturate.
    function automatic logic [CFG_W:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W:0] hi);
        logic [CFG_W:0] r;
        if (v == '0) begin
            r = (CFG_W+1)'(1);
        end else if ({1'b0, v} > hi) begin
            r = hi;
        end else begin
            r = {1'b0, v};
        end
        return r;
    endfunction

endpackage

// ===== design/frame_delta_run_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_delta_run_encoder
// An accepted pixel is registered in the run stage, its tokens in the burst
// register, each token then in the output register, one token per cycle while
// i_stall is low; a pixel causes up to four tokens and holds the token stage.
// The previous-frame memory is read and written once per pixel (read-first).
// Reset clears control state only; the frame memory is not cleared, and the
// first frame after reset is always sent as a resize frame.
// ----------------------------------------------------------------------------
module frame_delta_run_encoder
    import fdre_pkg::*;
#(
    parameter int W_LIMIT = W_LIMIT_DEF,
    parameter int H_LIMIT = H_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_token_kind,
    output logic [PIX_W-1:0]     o_token_value,
    output logic [EXTRA_W-1:0]   o_token_extra,
    output logic                 o_last_of_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = W_LIMIT * H_LIMIT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int DW     = $clog2(W_LIMIT + 1);
    localparam int DH     = $clog2(H_LIMIT + 1);
    localparam logic [CFG_W:0] MAX_W_C = (CFG_W+1)'(W_LIMIT);
    localparam logic [CFG_W:0] MAX_H_C = (CFG_W+1)'(H_LIMIT);

    logic [CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [DW-1:0]      r_st_w;
    logic [DH-1:0]      r_st_h;
    logic [TOT_W-1:0]   r_total;
    logic [ADDR_W-1:0]  r_pos;
    logic               r_full;
    logic [PIX_W-1:0]   r_mem [DEPTH];
    logic [PIX_W-1:0]   r_rd;
    logic               r_s1_valid;
    t_stage             r_s1;
    logic               r_in_diff;
    logic [TOT_W-1:0]   r_run;
    t_token             r_bst [BURST_DEPTH];
    logic [2:0]         r_bst_left;
    logic [1:0]         r_bst_i;
    logic               r_out_valid;
    t_token             r_out;
    logic               r_out_last;

    logic               in_acc, cfg_acc;
    logic               first, resize, mode_full, last;
    logic [DW-1:0]      w_c;
    logic [DH-1:0]      h_c;
    logic [DW+DH-1:0]   prod;
    logic [TOT_W-1:0]   pos_p1;
    logic               out_load, bst_emit, bst_free, s1_consume;
    logic               same;
    logic               n_in_diff;
    logic [TOT_W-1:0]   n_run;
    t_token             n_list [BURST_DEPTH];
    logic [2:0]         n_cnt;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= FRAME_WIDTH_RST;
            r_cfg_h <= FRAME_HEIGHT_RST;
        end else if (cfg_acc) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    // Frame-level control.
    assign w_c       = DW'(clamp_dim(r_cfg_w, MAX_W_C));
    assign h_c       = DH'(clamp_dim(r_cfg_h, MAX_H_C));
    assign prod      = w_c * h_c;
    assign first     = (r_pos == '0);
    assign resize    = (w_c != r_st_w) || (h_c != r_st_h);
    assign mode_full = first ? resize : r_full;
    assign pos_p1    = TOT_W'({1'b0, r_pos}) + TOT_W'(1);
    assign last      = first ? ((w_c == DW'(1)) && (h_c == DH'(1))) : (pos_p1 == r_total);

    assign bst_free   = (r_bst_left == 3'd0) || ((r_bst_left == 3'd1) && bst_emit);
    assign s1_consume = r_s1_valid & bst_free;
    assign o_stall    = r_s1_valid & ~bst_free;
    assign in_acc     = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_w  <= '0;
            r_st_h  <= '0;
            r_total <= '0;
            r_pos   <= '0;
            r_full  <= 1'b0;
        end else if (in_acc) begin
            if (first) begin
                r_st_w  <= w_c;
                r_st_h  <= h_c;
                r_total <= prod[TOT_W-1:0];
                r_full  <= resize;
            end
            r_pos <= last ? '0 : ADDR_W'(pos_p1);
        end
    end

    // Previous frame: read-first, one access per accepted pixel.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_pos] <= i_pixel;
            r_rd         <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.pixel  <= i_pixel;
            r_s1.first  <= first;
            r_s1.resize <= first & resize;
            r_s1.full   <= mode_full;
            r_s1.last   <= last;
        end
    end

    // Token list of the pixel in the run stage.
    always_comb begin
        logic             diff;
        logic [TOT_W-1:0] run;
        diff = r_s1.first ? 1'b0 : r_in_diff;
        run  = r_s1.first ? '0 : r_run;
        same = (r_rd == r_s1.pixel);
        n_cnt = 3'd0;
        for (int k = 0; k < BURST_DEPTH; k++) begin
            n_list[k] = mk_tok(KIND_NEW, '0, '0);
        end
        if (r_s1.first) begin
            if (r_s1.resize) begin
                n_list[n_cnt[1:0]] = mk_tok(KIND_RESIZE, PIX_W'(r_st_w), EXTRA_W'(r_st_h));
                n_cnt = n_cnt + 3'd1;
                n_list[n_cnt[1:0]] = mk_tok(KIND_LEAD, PIX_W'(r_total), '0);
                n_cnt = n_cnt + 3'd1;
            end else begin
                n_list[n_cnt[1:0]] = mk_tok(KIND_NEW, '0, '0);
                n_cnt = n_cnt + 3'd1;
            end
        end
        if (r_s1.full) begin
            n_list[n_cnt[1:0]] = mk_tok(KIND_LIT, r_s1.pixel, '0);
            n_cnt = n_cnt + 3'd1;
        end else if (!diff) begin
            if (same) begin
                run = run + TOT_W'(1);
            end else begin
                n_list[n_cnt[1:0]] = mk_tok(KIND_SAME, PIX_W'(run), '0);
                n_cnt = n_cnt + 3'd1;
                n_list[n_cnt[1:0]] = mk_tok(KIND_LIT, r_s1.pixel, '0);
                n_cnt = n_cnt + 3'd1;
                diff = 1'b1;
                run  = TOT_W'(1);
            end
        end else begin
            if (same) begin
                n_list[n_cnt[1:0]] = mk_tok(KIND_TRAIL, PIX_W'(run), '0);
                n_cnt = n_cnt + 3'd1;
                diff = 1'b0;
                run  = TOT_W'(1);
            end else begin
                n_list[n_cnt[1:0]] = mk_tok(KIND_LIT, r_s1.pixel, '0);
                n_cnt = n_cnt + 3'd1;
                run = run + TOT_W'(1);
            end
        end
        if (r_s1.last) begin
            if (!r_s1.full) begin
                if (diff) begin
                    n_list[n_cnt[1:0]] = mk_tok(KIND_TRAIL, PIX_W'(run), '0);
                    n_cnt = n_cnt + 3'd1;
                end else begin
                    n_list[n_cnt[1:0]] = mk_tok(KIND_SAME, PIX_W'(run), '0);
                    n_cnt = n_cnt + 3'd1;
                    n_list[n_cnt[1:0]] = mk_tok(KIND_TRAIL, '0, '0);
                    n_cnt = n_cnt + 3'd1;
                end
            end
            diff = 1'b0;
            run  = '0;
        end
        n_in_diff = diff;
        n_run     = run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_diff <= 1'b0;
            r_run     <= '0;
        end else if (s1_consume) begin
            r_in_diff <= n_in_diff;
            r_run     <= n_run;
        end
    end

    // Token burst: drain one per cycle into the output register while it can load.
    assign out_load = ~r_out_valid | ~i_stall;
    assign bst_emit = out_load & (r_bst_left != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst_left <= 3'd0;
            r_bst_i    <= 2'd0;
        end else if (s1_consume) begin
            r_bst_left <= n_cnt;
            r_bst_i    <= 2'd0;
        end else if (bst_emit) begin
            r_bst_left <= r_bst_left - 3'd1;
            r_bst_i    <= r_bst_i + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_consume) begin
            for (int k = 0; k < BURST_DEPTH; k++) begin
                r_bst[k] <= n_list[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= bst_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bst_emit) begin
            r_out      <= r_bst[r_bst_i];
            r_out_last <= (r_bst_left == 3'd1);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_token_kind   = r_out.kind;
    assign o_token_value  = r_out.value;
    assign o_token_extra  = r_out.extra;
    assign o_last_of_item = r_out_last;

    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bst_left <= 3'd4)
        else $error("token burst count out of range");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (TOT_W'({1'b0, r_pos}) < r_total))
        else $error("pixel position beyond frame size");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted pixel lost before run stage");

    a_resize_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.resize) |-> (r_s1.full && r_s1.first))
        else $error("resize pixel not in full-frame mode");

endmodule

// ===== tb/sv/frame_delta_run_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_delta_run_checker
// Watches the pixel, token and register channels of the frame delta run
// encoder. It keeps its own copy of the frame size registers, the previous
// frame and the run state, works out the tokens that each accepted pixel
// causes, and checks every accepted token field by field against the oldest
// one still owed.
// ----------------------------------------------------------------------------
module frame_delta_run_checker
    import fdre_pkg::*;
#(
    parameter int W_LIMIT = W_LIMIT_DEF,
    parameter int H_LIMIT = H_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pixel_valid,
    input  logic               i_pixel_stall,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_token_valid,
    input  logic               i_token_stall,
    input  logic [2:0]         i_token_kind,
    input  logic [PIX_W-1:0]   i_token_value,
    input  logic [EXTRA_W-1:0] i_token_extra,
    input  logic               i_last_of_item,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_tokens_owed,
    output int                 o_mismatches
);

    typedef struct {
        t_kind              kind;
        logic [PIX_W-1:0]   value;
        logic [EXTRA_W-1:0] extra;
        logic               last;
    } t_owed_token;

    t_owed_token        owed_tokens[$];
    t_owed_token        oldest;
    logic [PIX_W-1:0]   prev_frame[int];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    int unsigned        frame_w;
    int unsigned        frame_h;
    int unsigned        pix_pos;
    int unsigned        run_count;
    logic               full_frame;
    logic               in_literal;
    int                 mismatches = 0;

    function automatic int unsigned bound_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0) return 1;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic void owe_token(input t_kind kind, input logic [PIX_W-1:0] value,
                                      input logic [EXTRA_W-1:0] extra);
        t_owed_token t;
        t.kind  = kind;
        t.value = value;
        t.extra = extra;
        t.last  = 1'b0;
        owed_tokens.insert(owed_tokens.size(), t);
    endfunction

    task automatic encode_pixel(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int          first;
        logic        same;
        first = owed_tokens.size();
        if (pix_pos == 0) begin
            w = bound_dim(width_reg, W_LIMIT);
            h = bound_dim(height_reg, H_LIMIT);
            if (w != frame_w || h != frame_h) begin
                frame_w    = w;
                frame_h    = h;
                full_frame = 1'b1;
                owe_token(KIND_RESIZE, PIX_W'(w), EXTRA_W'(h));
                owe_token(KIND_LEAD, PIX_W'(w * h), '0);
            end else begin
                full_frame = 1'b0;
                owe_token(KIND_NEW, '0, '0);
            end
            in_literal = 1'b0;
            run_count  = 0;
        end
        if (full_frame) begin
            owe_token(KIND_LIT, px, '0);
        end else begin
            same = prev_frame.exists(pix_pos) ? (prev_frame[pix_pos] == px) : (px == '0);
            if (!in_literal) begin
                if (same) begin
                    run_count++;
                end else begin
                    owe_token(KIND_SAME, PIX_W'(run_count), '0);
                    owe_token(KIND_LIT, px, '0);
                    in_literal = 1'b1;
                    run_count  = 1;
                end
            end else if (same) begin
                owe_token(KIND_TRAIL, PIX_W'(run_count), '0);
                in_literal = 1'b0;
                run_count  = 1;
            end else begin
                owe_token(KIND_LIT, px, '0);
                run_count++;
            end
        end
        prev_frame[pix_pos] = px;
        pix_pos++;
        if (pix_pos >= frame_w * frame_h) begin
            // flush the open run at frame end
            if (!full_frame) begin
                if (in_literal) begin
                    owe_token(KIND_TRAIL, PIX_W'(run_count), '0);
                end else begin
                    owe_token(KIND_SAME, PIX_W'(run_count), '0);
                    owe_token(KIND_TRAIL, '0, '0);
                end
            end
            pix_pos    = 0;
            in_literal = 1'b0;
            run_count  = 0;
        end
        if (owed_tokens.size() > first) begin
            owed_tokens[owed_tokens.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_tokens.delete();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            frame_w    = 0;
            frame_h    = 0;
            pix_pos    = 0;
            run_count  = 0;
            full_frame = 1'b0;
            in_literal = 1'b0;
        end else begin
            if (i_token_valid && !i_token_stall) begin
                if (owed_tokens.size() == 0) begin
                    $error("token_kind %0d with value %h arrived with nothing owed",
                           i_token_kind, i_token_value);
                    mismatches++;
                end else begin
                    oldest = owed_tokens.pop_front();
                    if (i_token_kind !== oldest.kind) begin
                        $error("token_kind: expected %0d, got %0d", oldest.kind, i_token_kind);
                        mismatches++;
                    end
                    if (i_token_value !== oldest.value) begin
                        $error("token_value: expected %h, got %h", oldest.value, i_token_value);
                        mismatches++;
                    end
                    if (i_token_extra !== oldest.extra) begin
                        $error("token_extra: expected %0d, got %0d", oldest.extra, i_token_extra);
                        mismatches++;
                    end
                    if (i_last_of_item !== oldest.last) begin
                        $error("last_of_item: expected %0b, got %0b", oldest.last, i_last_of_item);
                        mismatches++;
                    end
                end
            end
            if (i_pixel_valid && !i_pixel_stall) begin
                encode_pixel(i_pixel);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
        end
        o_tokens_owed <= owed_tokens.size();
        o_mismatches  <= mismatches;
    end

endmodule

// ===== tb/sv/tb_frame_delta_run_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_delta_run_encoder
// Drives frames of pixels and frame size writes into the frame delta run
// encoder: a few hand-built frames for run boundaries, random small frames
// whose pixels mostly repeat or differ from the previous frame in runs, then
// the opening of a frame whose width saturates at the limit and whose zero height
// counts as one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_frame_delta_run_encoder;
    import fdre_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RANDOM_ITEMS  = 270;
    localparam int SAT_ITEMS     = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef enum {
        SRC_GIVEN,
        SRC_KEEP,
        SRC_FLIP,
        SRC_AUTO
    } t_pix_src;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid;
    logic               o_stall;
    logic [PIX_W-1:0]   i_pixel;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_token_kind;
    logic [PIX_W-1:0]   o_token_value;
    logic [EXTRA_W-1:0] o_token_extra;
    logic               o_last_of_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    int                 tokens_owed;
    int                 mismatches;
    int unsigned        cycles = 0;
    int                 hold_req = 0;
    int                 holds_done = 0;
    bit                 tx_quiet = 1'b0;
    bit                 keep_run = 1'b1;
    bit                 delta_frame = 1'b0;
    logic [CFG_W-1:0]   cfg_w = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]   cfg_h = FRAME_HEIGHT_RST;
    int unsigned        cur_w = 0;
    int unsigned        cur_h = 0;
    int unsigned        pix_index = 0;
    logic [PIX_W-1:0]   sent_px[int];

    frame_delta_run_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_value  (o_token_value),
        .o_token_extra  (o_token_extra),
        .o_last_of_item (o_last_of_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    frame_delta_run_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_valid),
        .i_pixel_stall  (o_stall),
        .i_pixel        (i_pixel),
        .i_token_valid  (o_valid),
        .i_token_stall  (i_stall),
        .i_token_kind   (o_token_kind),
        .i_token_value  (o_token_value),
        .i_token_extra  (o_token_extra),
        .i_last_of_item (o_last_of_item),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_tokens_owed  (tokens_owed),
        .o_mismatches   (mismatches)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0) return 1;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] auto_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 3) return '0;
        if (r < 6) return '1;
        if (!delta_frame || r < 10) return $urandom;
        if ($urandom_range(2) == 0) keep_run = !keep_run;
        if (keep_run) return sent_px[pix_index];
        if ($urandom_range(1) == 0) return sent_px[pix_index] ^ (32'h1 << $urandom_range(31));
        return sent_px[pix_index] ^ ($urandom | 32'h1);
    endfunction

    task automatic send_pixel(input t_pix_src src, input logic [PIX_W-1:0] given);
        int               gap;
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] px;
        if (pix_index == 0) begin
            w = fit_dim(cfg_w, W_LIMIT_DEF);
            h = fit_dim(cfg_h, H_LIMIT_DEF);
            delta_frame = (w == cur_w && h == cur_h);
            cur_w = w;
            cur_h = h;
        end
        case (src)
            SRC_GIVEN: px = given;
            SRC_KEEP:  px = sent_px[pix_index];
            SRC_FLIP:  px = ~sent_px[pix_index];
            default:   px = auto_pixel();
        endcase
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        sent_px[pix_index] = px;
        pix_index++;
        if (pix_index == cur_w * cur_h) pix_index = 0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_w = w;
        cfg_h = h;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // token receiver: random stall stretches, quiet stretches, requested hold-offs
    initial begin
        int len;
        int seg;
        bit quiet;
        i_stall = 1'b0;
        seg = 0;
        quiet = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req != holds_done) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(80, 20);
                    quiet = ($urandom_range(3) == 0);
                end
                seg--;
                len = pick_gap(quiet);
                i_stall <= (len > 0);
                repeat ((len > 0) ? len : 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [PIX_W-1:0] edge_px[6];
        logic [5:0]       diff_pats[3];
        int               sent;
        int               burst;
        bit               held;
        edge_px   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001,
                      32'h7FFF_FFFE, 32'hA5A5_5A5A, 32'h0000_0001};
        // bit i set: pixel i differs from the previous frame
        diff_pats = '{6'b100110, 6'b001001, 6'b000000};
        i_valid     = 1'b0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(12'd3, 12'd2);
        for (int i = 0; i < 6; i++) send_pixel(SRC_GIVEN, edge_px[i]);
        for (int p = 0; p < 3; p++) begin
            for (int i = 0; i < 6; i++) send_pixel(diff_pats[p][i] ? SRC_FLIP : SRC_KEEP, '0);
        end

        drain();
        set_size(12'($urandom_range(8, 0)), 12'($urandom_range(5, 0)));

        sent = 0;
        held = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                drain();
                if ($urandom_range(1) == 0) begin
                    set_size(12'($urandom_range(8, 0)), 12'($urandom_range(5, 0)));
                end else begin
                    set_size(cfg_w, cfg_h);
                end
            end
            if (!held && sent >= 150) begin
                held = 1'b1;
                i_valid <= 1'b0;
                hold_req++;
                wait (holds_done == hold_req);
                @(posedge i_clk);
            end
            tx_quiet = ($urandom_range(3) == 0);
            burst = $urandom_range(30, 4);
            repeat (burst) begin
                send_pixel(SRC_AUTO, '0);
                sent++;
            end
        end
        while (pix_index != 0) send_pixel(SRC_AUTO, '0);
        drain();

        set_size(12'hFFF, 12'h000);
        repeat (SAT_ITEMS) send_pixel(SRC_AUTO, '0);
        drain();

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
